// ===== rtl/core/frcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frcc_pkg
// Types and fixed constants of the flash record CRC checker.
// ----------------------------------------------------------------------------
package frcc_pkg;

  // Input item: one byte of the stored record
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result item: one status per record
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] computed_crc;
  } out_item_t;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd3;
  localparam logic [2:0] ST_BAD_CRC     = 3'd4;
  localparam logic [2:0] ST_BAD_LEN     = 3'd5;

  // Configuration register indexes
  localparam int          CFG_IDX_W   = 1;
  localparam logic [0:0]  CFG_MAGIC   = 1'b0;
  localparam logic [0:0]  CFG_VERSION = 1'b1;

  localparam logic [31:0] MAGIC_RESET   = 32'h4359_434C;
  localparam logic [15:0] VERSION_RESET = 16'h0001;

  // Reflected CRC-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Byte position counter, saturating
  localparam int               POS_W   = 13;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

endpackage

// ===== rtl/core/flash_record_crc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_record_crc_checker
// Checks a stored record byte by byte: header capture, CRC-32 and status.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | input     | in_valid/in_ready  | data_byte, last_byte
//  out     | output    | out_valid/out_ready| status, computed_crc
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
//  One byte per cycle. A byte is held in the input register, then is
//  folded into the CRC and header state; the status of a last byte is
//  worked out as it leaves the input register and held in the result register.
//  Synchronous reset clears the record state and restores the register
//  defaults. Only a last byte waits on a full result register; other bytes
//  keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module flash_record_crc_checker #(
  parameter int DB_BYTES = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  frcc_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output frcc_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [frcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int CRC_END = DB_BYTES + 8;
  localparam int REC_LEN = CRC_END + 4;
  localparam int PW      = frcc_pkg::POS_W;

  // configuration
  logic [31:0] expected_magic;
  logic [15:0] expected_version;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_fire;

  // record state
  logic [31:0]   crc_reg, crc_next, crc_upd;
  logic [PW-1:0] byte_position, byte_position_next;
  logic [31:0]   magic_seen, magic_next;
  logic [15:0]   version_seen, version_next;
  logic [15:0]   size_seen, size_next;
  logic [31:0]   stored_crc, stored_next;
  logic [PW-1:0] crc_off;
  logic [2:0]    status_next;
  logic [31:0]   final_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= frcc_pkg::MAGIC_RESET;
      expected_version <= frcc_pkg::VERSION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        frcc_pkg::CFG_MAGIC:   expected_magic   <= cfg_data;
        frcc_pkg::CFG_VERSION: expected_version <= cfg_data[15:0];
      endcase
    end
  end

  // A last byte may only move on when the result register is free
  assign s1_fire  = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_item.data_byte;
      s1_last <= in_item.last_byte;
    end
  end

  frcc_crc_byte u_crc (
    .crc_in  (crc_reg),
    .data    (s1_byte),
    .crc_out (crc_upd)
  );

  assign crc_off = byte_position - PW'(CRC_END);

  always_comb begin
    crc_next     = crc_reg;
    magic_next   = magic_seen;
    version_next = version_seen;
    size_next    = size_seen;
    stored_next  = stored_crc;

    if (byte_position < PW'(CRC_END)) begin
      crc_next = crc_upd;
    end

    // capture header and stored CRC lanes, little-endian
    if (byte_position < PW'(4)) begin
      magic_next[{byte_position[1:0], 3'b000} +: 8] = s1_byte;
    end else if (byte_position < PW'(6)) begin
      version_next[{byte_position[0], 3'b000} +: 8] = s1_byte;
    end else if (byte_position < PW'(8)) begin
      size_next[{byte_position[0], 3'b000} +: 8] = s1_byte;
    end else if (byte_position >= PW'(CRC_END) && byte_position < PW'(REC_LEN)) begin
      stored_next[{crc_off[1:0], 3'b000} +: 8] = s1_byte;
    end

    byte_position_next = byte_position;
    if (byte_position != frcc_pkg::POS_MAX) begin
      byte_position_next = byte_position + PW'(1);
    end

    final_crc = ~crc_next;
    if (byte_position != PW'(REC_LEN - 1)) begin
      status_next = frcc_pkg::ST_BAD_LEN;
    end else if (magic_next != expected_magic) begin
      status_next = frcc_pkg::ST_BAD_MAGIC;
    end else if (version_next != expected_version) begin
      status_next = frcc_pkg::ST_BAD_VERSION;
    end else if (size_next != 16'(DB_BYTES)) begin
      status_next = frcc_pkg::ST_BAD_SIZE;
    end else if (final_crc != stored_next) begin
      status_next = frcc_pkg::ST_BAD_CRC;
    end else begin
      status_next = frcc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_fire && s1_last)) begin
      // clear for the next record
      crc_reg       <= frcc_pkg::CRC_INIT;
      byte_position <= '0;
      magic_seen    <= '0;
      version_seen  <= '0;
      size_seen     <= '0;
      stored_crc    <= '0;
    end else if (s1_fire) begin
      crc_reg       <= crc_next;
      byte_position <= byte_position_next;
      magic_seen    <= magic_next;
      version_seen  <= version_next;
      size_seen     <= size_next;
      stored_crc    <= stored_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last) begin
      out_item.status       <= status_next;
      out_item.computed_crc <= final_crc;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_result : assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> out_valid)
    else $error("last item did not produce a result");

  a_record_cleared : assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> (byte_position == '0 && crc_reg == frcc_pkg::CRC_INIT))
    else $error("record state not cleared after last item");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(s1_fire && s1_last))
    else $error("pending result overwritten");

  a_status_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status <= frcc_pkg::ST_BAD_LEN)
    else $error("status code out of range");
`endif

endmodule

// ===== rtl/core/frcc_crc_byte.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frcc_crc_byte
// One byte step of the reflected CRC-32, unrolled over the eight bits.
// ----------------------------------------------------------------------------
module frcc_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = {1'b0, c[31:1]} ^ (frcc_pkg::CRC_POLY & {32{c[0]}});
    end
    crc_out = c;
  end

endmodule
